// ===== rtl/info_frame_byte_stuffer_top_defines.svh =====
// Assertion macros shared by the byte stuffer RTL
`ifndef INFO_FRAME_BYTE_STUFFER_TOP_DEFINES_SVH
`define INFO_FRAME_BYTE_STUFFER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle during reset
`define IFBS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ifbs: implication check failed");

// Next-cycle implication, sampled on clk, idle during reset
`define IFBS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ifbs: next-cycle check failed");

`endif

// ===== rtl/ifbs_pkg.sv =====
// Shared types and constants for the information frame byte stuffer
`timescale 1ns / 1ps
`default_nettype none

package ifbs_pkg;

    localparam int BYTE_W     = 8;
    localparam int NUM_SLOTS  = 9;
    localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register reset values
    localparam logic [BYTE_W-1:0] FLAG_RST   = 8'h7E;
    localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'h7D;
    localparam logic [BYTE_W-1:0] MASK_RST   = 8'h20;
    localparam logic [BYTE_W-1:0] ADDR_RST   = 8'h03;
    localparam logic [BYTE_W-1:0] CTRL0_RST  = 8'h00;
    localparam logic [BYTE_W-1:0] CTRL1_RST  = 8'h40;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_FLAG   = 3'd0,
        REG_ESCAPE = 3'd1,
        REG_MASK   = 3'd2,
        REG_ADDR   = 3'd3,
        REG_CTRL0  = 3'd4,
        REG_CTRL1  = 3'd5
    } reg_idx_t;

    // Slot order of the bytes one request can produce
    localparam int SLOT_OPEN_FLAG = 0;
    localparam int SLOT_ADDR      = 1;
    localparam int SLOT_CTRL      = 2;
    localparam int SLOT_HCHECK    = 3;
    localparam int SLOT_DATA_ESC  = 4;
    localparam int SLOT_DATA      = 5;
    localparam int SLOT_CHK_ESC   = 6;
    localparam int SLOT_CHK       = 7;
    localparam int SLOT_CLOSE     = 8;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_byte;
        logic [BYTE_W-1:0] escape_byte;
        logic [BYTE_W-1:0] stuff_mask;
        logic [BYTE_W-1:0] address_byte;
        logic [BYTE_W-1:0] control_seq0;
        logic [BYTE_W-1:0] control_seq1;
    } cfg_t;

    // One request worth of line bytes, with a mask of the slots in use
    typedef struct packed {
        logic [NUM_SLOTS-1:0][BYTE_W-1:0] bytes;
        logic [NUM_SLOTS-1:0]             mask;
    } job_t;

endpackage

`default_nettype wire

// ===== rtl/ifbs_in_if.sv =====
// Payload byte channel: valid/ready handshake with one unstuffed byte
`timescale 1ns / 1ps
`default_nettype none

interface ifbs_in_if
    import ifbs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    logic              seq_bit;

    modport source (output valid, output data_byte, output last_byte, output seq_bit,
                    input ready);
    modport sink   (input valid, input data_byte, input last_byte, input seq_bit,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/ifbs_out_if.sv =====
// Line byte channel: valid/ready handshake with one stuffed byte
`timescale 1ns / 1ps
`default_nettype none

interface ifbs_out_if
    import ifbs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              frame_end;

    modport source (output valid, output out_byte, output run_last, output frame_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input frame_end,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/ifbs_regs.sv =====
// APB configuration registers of the byte stuffer
`timescale 1ns / 1ps
`default_nettype none

module ifbs_regs
    import ifbs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    logic [2:0]        reg_sel;
    logic              wr_en;
    logic [BYTE_W-1:0] wr_byte;
    logic [BYTE_W-1:0] rd_byte;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign wr_byte = pwdata[BYTE_W-1:0];
    assign cfg     = cfg_reg;

    // Decode the write; unknown indexes drop the request
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_FLAG:   cfg_next.flag_byte    = wr_byte;
                REG_ESCAPE: cfg_next.escape_byte  = wr_byte;
                REG_MASK:   cfg_next.stuff_mask   = wr_byte;
                REG_ADDR:   cfg_next.address_byte = wr_byte;
                REG_CTRL0:  cfg_next.control_seq0 = wr_byte;
                REG_CTRL1:  cfg_next.control_seq1 = wr_byte;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_sel)
            REG_FLAG:   rd_byte = cfg_reg.flag_byte;
            REG_ESCAPE: rd_byte = cfg_reg.escape_byte;
            REG_MASK:   rd_byte = cfg_reg.stuff_mask;
            REG_ADDR:   rd_byte = cfg_reg.address_byte;
            REG_CTRL0:  rd_byte = cfg_reg.control_seq0;
            REG_CTRL1:  rd_byte = cfg_reg.control_seq1;
            default:    rd_byte = '0;
        endcase
    end

    assign prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, rd_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_byte    <= FLAG_RST;
            cfg_reg.escape_byte  <= ESCAPE_RST;
            cfg_reg.stuff_mask   <= MASK_RST;
            cfg_reg.address_byte <= ADDR_RST;
            cfg_reg.control_seq0 <= CTRL0_RST;
            cfg_reg.control_seq1 <= CTRL1_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ifbs_framer.sv =====
// Input register, frame state and expansion of one request into line bytes
`timescale 1ns / 1ps
`default_nettype none

`include "info_frame_byte_stuffer_top_defines.svh"

module ifbs_framer
    import ifbs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    ifbs_in_if.sink   src,
    input  wire logic job_free,
    output logic      job_load,
    output job_t      job
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              last_reg;
    logic              seq_reg;
    logic              in_frame_reg;
    logic              in_frame_next;
    logic [BYTE_W-1:0] check_reg;
    logic [BYTE_W-1:0] check_next;

    logic              accept;
    logic              first;
    logic [BYTE_W-1:0] ctrl;
    logic [BYTE_W-1:0] chk_val;
    logic              data_esc;
    logic              chk_esc;

    // Take a new request when the register is empty or moves on this cycle
    assign src.ready = !in_valid_reg || job_free;
    assign accept    = src.valid && src.ready;
    assign job_load  = in_valid_reg && job_free;

    assign first    = !in_frame_reg;
    assign ctrl     = seq_reg ? cfg.control_seq1 : cfg.control_seq0;
    assign chk_val  = (first ? '0 : check_reg) ^ data_reg;
    assign data_esc = (data_reg == cfg.flag_byte) || (data_reg == cfg.escape_byte);
    assign chk_esc  = (chk_val == cfg.flag_byte) || (chk_val == cfg.escape_byte);

    // Build every slot; the mask picks which ones go on the line
    always_comb
    begin
        job.bytes                 = '0;
        job.bytes[SLOT_OPEN_FLAG] = cfg.flag_byte;
        job.bytes[SLOT_ADDR]      = cfg.address_byte;
        job.bytes[SLOT_CTRL]      = ctrl;
        job.bytes[SLOT_HCHECK]    = cfg.address_byte ^ ctrl;
        job.bytes[SLOT_DATA_ESC]  = cfg.escape_byte;
        job.bytes[SLOT_DATA]      = data_esc ? (data_reg ^ cfg.stuff_mask) : data_reg;
        job.bytes[SLOT_CHK_ESC]   = cfg.escape_byte;
        job.bytes[SLOT_CHK]       = chk_esc ? (chk_val ^ cfg.stuff_mask) : chk_val;
        job.bytes[SLOT_CLOSE]     = cfg.flag_byte;

        job.mask                 = '0;
        job.mask[SLOT_OPEN_FLAG] = first;
        job.mask[SLOT_ADDR]      = first;
        job.mask[SLOT_CTRL]      = first;
        job.mask[SLOT_HCHECK]    = first;
        job.mask[SLOT_DATA_ESC]  = data_esc;
        job.mask[SLOT_DATA]      = 1'b1;
        job.mask[SLOT_CHK_ESC]   = last_reg && chk_esc;
        job.mask[SLOT_CHK]       = last_reg;
        job.mask[SLOT_CLOSE]     = last_reg;
    end

    // Advance the input register and the frame state
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (job_load)
        begin
            in_valid_next = 1'b0;
        end

        in_frame_next = in_frame_reg;
        check_next    = check_reg;
        if (job_load)
        begin
            in_frame_next = !last_reg;
            check_next    = last_reg ? '0 : chk_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_frame_reg <= 1'b0;
            check_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            in_frame_reg <= in_frame_next;
            check_reg    <= check_next;
        end
    end

    // Payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= src.data_byte;
            last_reg <= src.last_byte;
            seq_reg  <= src.seq_bit;
        end
    end

    `IFBS_ASSERT_NXT(a_last_closes_frame, job_load && last_reg, !in_frame_reg)
    `IFBS_ASSERT_NXT(a_last_clears_check, job_load && last_reg, check_reg == '0)
    `IFBS_ASSERT_NXT(a_held_request_stays, in_valid_reg && !job_free,
                     in_valid_reg && data_reg == $past(data_reg))

endmodule

`default_nettype wire

// ===== rtl/ifbs_emitter.sv =====
// Slot register and output register: sends one line byte per cycle while the line is ready
`timescale 1ns / 1ps
`default_nettype none

`include "info_frame_byte_stuffer_top_defines.svh"

module ifbs_emitter
    import ifbs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_load,
    input  wire job_t job,
    output logic      job_free,
    ifbs_out_if.source dst
);

    logic [NUM_SLOTS-1:0][BYTE_W-1:0] bytes_reg;
    logic [NUM_SLOTS-1:0]             mask_reg;
    logic [NUM_SLOTS-1:0]             mask_next;
    logic [NUM_SLOTS-1:0]             mask_rest;
    logic [SLOT_IDX_W-1:0]            idx;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              run_last_reg;
    logic              frame_end_reg;

    logic out_free;
    logic pop;

    // Lowest pending slot goes next
    always_comb
    begin
        idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                idx = SLOT_IDX_W'(i);
            end
        end
    end

    assign out_free  = !out_valid_reg || dst.ready;
    assign pop       = out_free && (mask_reg != '0);
    assign mask_rest = mask_reg & ~(NUM_SLOTS'(1) << idx);
    assign job_free  = (mask_reg == '0) || (pop && (mask_rest == '0));

    // Advance slot mask and output valid
    always_comb
    begin
        mask_next = mask_reg;
        if (job_load)
        begin
            mask_next = job.mask;
        end
        else if (pop)
        begin
            mask_next = mask_rest;
        end

        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (dst.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Slot bytes and output payload
    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            bytes_reg <= job.bytes;
        end
        if (pop)
        begin
            out_byte_reg  <= bytes_reg[idx];
            run_last_reg  <= (mask_rest == '0);
            frame_end_reg <= (idx == SLOT_IDX_W'(SLOT_CLOSE));
        end
    end

    assign dst.valid     = out_valid_reg;
    assign dst.out_byte  = out_byte_reg;
    assign dst.run_last  = run_last_reg;
    assign dst.frame_end = frame_end_reg;

    `IFBS_ASSERT_IMP(a_close_ends_run, out_valid_reg && frame_end_reg, run_last_reg)
    `IFBS_ASSERT_NXT(a_stall_holds_slots, out_valid_reg && !dst.ready && !job_load,
                     mask_reg == $past(mask_reg))
    `IFBS_ASSERT_NXT(a_load_has_bytes, job_load, mask_reg != '0)

endmodule

`default_nettype wire

// ===== rtl/info_frame_byte_stuffer_top.sv =====
// Top level of the information frame byte stuffer
//
//  channel   dir  handshake         payload
//  payload   in   valid/ready       data_byte[7:0], last_byte, seq_bit
//  line      out  valid/ready       out_byte[7:0], run_last, frame_end
//  apb       in   psel/penable      paddr[4:0], pwdata[31:0] -> prdata[31:0]
//
// The line side sends one byte per cycle while the line is ready; a payload
// byte becomes 1 to 9 line bytes (header on a frame's first byte, escape pairs,
// check and closing flag on the last), so the output register's drain sets the rate.
// An accepted request reaches the line through the input register, then the
// slot register, then the output register.
// Reset clears the frame state and loads the register defaults; no clearing pass.
// A stalled line holds the output register and the slot register; the input
// register still takes one request ahead, then the payload side waits until
// the slot register sends its last byte.
`timescale 1ns / 1ps
`default_nettype none

module info_frame_byte_stuffer_top
    import ifbs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    ifbs_in_if.sink                    payload,
    ifbs_out_if.source                 line
);

    cfg_t cfg;
    job_t job;
    logic job_load;
    logic job_free;

    ifbs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ifbs_framer u_framer (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .src      (payload),
        .job_free (job_free),
        .job_load (job_load),
        .job      (job)
    );

    ifbs_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_load (job_load),
        .job      (job),
        .job_free (job_free),
        .dst      (line)
    );

endmodule

`default_nettype wire
